>>> src/twqa_pkg.sv
`default_nettype none
package twqa_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_WIDTH    = 16;

	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int IN_ID_W = 16;
	localparam int WAIT_W  = 5;
	localparam int TOTAL_W = 6;
	localparam int LIMIT_W = 4;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(5);

	typedef enum logic [0:0] {
		REQ_ENQUEUE = 1'b0,
		REQ_DEQUEUE = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		CLASS_NORMAL = 2'd0,
		CLASS_URGENT = 2'd1
	} item_class_t;

	typedef enum logic [2:0] {
		ST_ADD_URGENT = 3'd0,
		ST_ADD_NORMAL = 3'd1,
		ST_BAD_CLASS  = 3'd2,
		ST_FULL       = 3'd3,
		ST_SERVED     = 3'd4,
		ST_EMPTY      = 3'd5
	} status_t;

	typedef struct packed {
		logic [0:0]         req_type;
		logic [IN_ID_W-1:0] item_id;
		logic [1:0]         item_class;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [IN_ID_W-1:0] served_id;
		logic               served_urgent;
		logic [WAIT_W-1:0]  urgent_waiting;
		logic [WAIT_W-1:0]  normal_waiting;
		logic [TOTAL_W-1:0] total_waiting;
	} rsp_t;

	typedef struct packed {
		status_t            status;
		logic               serve;
		logic               served_urgent;
		logic [WAIT_W-1:0]  urgent_waiting;
		logic [WAIT_W-1:0]  normal_waiting;
		logic [TOTAL_W-1:0] total_waiting;
	} pend_t;

endpackage
`default_nettype wire

>>> src/twqa_ram.sv
`default_nettype none
module twqa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> src/two_class_weighted_queue_arbiter.sv
// Two-class queue arbiter with a weighted urgent burst.
// Request channel (req_valid, req_stall, req): a word either enqueues an
// item id into the urgent or normal FIFO, or asks for the next item.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one word per
// request, with a status code, the served id and both queue counts.
// Configuration channel (cfg_valid, cfg_ready, cfg_data): writes the urgent
// burst limit; cfg_ready is always high. Write it only while idle.
// An accepted request is first held in the pending stage, while the read of
// the FIFO memory is registered alongside it, and then moves into the
// response register on rsp. Throughput: one request per cycle while
// req_stall is low. Heads, counts and the burst counter are updated at
// the accepting edge, so the next request sees them at once.
// When the receiver stalls, the response register holds its word, the
// pending stage fills behind it and then req_stall rises until the
// response is taken. Reset empties both FIFOs, clears the burst counter
// and sets the limit to 5; the FIFO memories themselves are not cleared.
`default_nettype none
module two_class_weighted_queue_arbiter
	import twqa_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output      logic               req_stall,
	input  wire req_t               req,
	output      logic               rsp_valid,
	input  wire logic               rsp_stall,
	output      rsp_t               rsp,
	input  wire logic               cfg_valid,
	output      logic               cfg_ready,
	input  wire logic [LIMIT_W-1:0] cfg_data
);

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	logic [LIMIT_W-1:0] limit_q;
	logic [LIMIT_W-1:0] burst_q, burst_d;
	ptr_t               u_head_q, u_head_d, n_head_q, n_head_d;
	cnt_t               u_count_q, u_count_d, n_count_q, n_count_d;

	logic               u_we, n_we, u_re, n_re;
	ptr_t               u_waddr, n_waddr;
	logic [ID_WIDTH-1:0] u_rdata, n_rdata, store_id;

	logic               accept, s1_move;
	logic               s1_valid_q;
	pend_t              s1_q, s1_d;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	logic               reached, u_has, n_has, u_full, n_full;
	logic [CNT_W:0]     total_sum;

	function automatic ptr_t wrap_tail(ptr_t head, cnt_t count);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(head) + (CNT_W+1)'(count);
		if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
			sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
		end
		return PTR_W'(sum);
	endfunction

	function automatic ptr_t next_head(ptr_t head);
		return (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + PTR_W'(1);
	endfunction

	twqa_ram #(.WIDTH(ID_WIDTH), .DEPTH(QUEUE_DEPTH)) u_urgent_ram (
		.clk   (clk),
		.we    (u_we),
		.waddr (u_waddr),
		.wdata (store_id),
		.re    (u_re),
		.raddr (u_head_q),
		.rdata (u_rdata)
	);

	twqa_ram #(.WIDTH(ID_WIDTH), .DEPTH(QUEUE_DEPTH)) u_normal_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (store_id),
		.re    (n_re),
		.raddr (n_head_q),
		.rdata (n_rdata)
	);

	assign cfg_ready = 1'b1;
	assign s1_move   = s1_valid_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = s1_valid_q && !s1_move;
	assign accept    = req_valid && !req_stall;
	assign store_id  = ID_WIDTH'(req.item_id);
	assign u_waddr   = wrap_tail(u_head_q, u_count_q);
	assign n_waddr   = wrap_tail(n_head_q, n_count_q);
	assign reached   = burst_q >= limit_q;
	assign u_has     = u_count_q != '0;
	assign n_has     = n_count_q != '0;
	assign u_full    = u_count_q == CNT_W'(QUEUE_DEPTH);
	assign n_full    = n_count_q == CNT_W'(QUEUE_DEPTH);

	always_comb begin
		u_we      = 1'b0;
		n_we      = 1'b0;
		u_re      = 1'b0;
		n_re      = 1'b0;
		u_head_d  = u_head_q;
		n_head_d  = n_head_q;
		u_count_d = u_count_q;
		n_count_d = n_count_q;
		burst_d   = burst_q;
		s1_d      = '0;
		s1_d.status = ST_EMPTY;
		if (req.req_type == REQ_ENQUEUE) begin
			case (req.item_class)
				CLASS_URGENT: begin
					if (u_full) begin
						s1_d.status = ST_FULL;
					end else begin
						u_we        = accept;
						u_count_d   = u_count_q + CNT_W'(1);
						s1_d.status = ST_ADD_URGENT;
					end
				end
				CLASS_NORMAL: begin
					if (n_full) begin
						s1_d.status = ST_FULL;
					end else begin
						n_we        = accept;
						n_count_d   = n_count_q + CNT_W'(1);
						s1_d.status = ST_ADD_NORMAL;
					end
				end
				default: s1_d.status = ST_BAD_CLASS;
			endcase
		end else if (n_has && (reached || !u_has)) begin
			n_re        = accept;
			n_head_d    = next_head(n_head_q);
			n_count_d   = n_count_q - CNT_W'(1);
			burst_d     = '0;
			s1_d.status = ST_SERVED;
			s1_d.serve  = 1'b1;
		end else if (u_has) begin
			u_re        = accept;
			u_head_d    = next_head(u_head_q);
			u_count_d   = u_count_q - CNT_W'(1);
			if (!reached) begin
				burst_d = burst_q + LIMIT_W'(1);
			end
			s1_d.status        = ST_SERVED;
			s1_d.serve         = 1'b1;
			s1_d.served_urgent = 1'b1;
		end
		total_sum           = (CNT_W+1)'(u_count_d) + (CNT_W+1)'(n_count_d);
		s1_d.urgent_waiting = WAIT_W'(u_count_d);
		s1_d.normal_waiting = WAIT_W'(n_count_d);
		s1_d.total_waiting  = TOTAL_W'(total_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			burst_q     <= '0;
			u_head_q    <= '0;
			n_head_q    <= '0;
			u_count_q   <= '0;
			n_count_q   <= '0;
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (accept) begin
				burst_q    <= burst_d;
				u_head_q   <= u_head_d;
				n_head_q   <= n_head_d;
				u_count_q  <= u_count_d;
				n_count_q  <= n_count_d;
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q <= s1_d;
		end
		if (s1_move) begin
			rsp_q.status         <= s1_q.status;
			rsp_q.served_urgent  <= s1_q.served_urgent;
			rsp_q.urgent_waiting <= s1_q.urgent_waiting;
			rsp_q.normal_waiting <= s1_q.normal_waiting;
			rsp_q.total_waiting  <= s1_q.total_waiting;
			if (!s1_q.serve) begin
				rsp_q.served_id <= '0;
			end else if (s1_q.served_urgent) begin
				rsp_q.served_id <= IN_ID_W'(u_rdata);
			end else begin
				rsp_q.served_id <= IN_ID_W'(n_rdata);
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		u_count_q <= CNT_W'(QUEUE_DEPTH) && n_count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_SERVED |-> rsp.served_id == '0 && !rsp.served_urgent)
		else $error("served fields set without a service");

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.total_waiting ==
			TOTAL_W'(rsp.urgent_waiting) + TOTAL_W'(rsp.normal_waiting))
		else $error("total does not match counts");

	a_pend_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_q)
		else $error("accepted word not pending");

	a_no_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(!u_re || u_has) && (!n_re || n_has))
		else $error("read of an empty queue");

endmodule
`default_nettype wire

>>> test/tb_two_class_weighted_queue_arbiter.sv
`default_nettype none
module tb_two_class_weighted_queue_arbiter;
	import twqa_pkg::*;

	localparam int          CYCLE_LIMIT  = 250000;
	localparam int          PRINT_LIMIT  = 40;
	localparam int          PHASE_ITEMS  = 200;
	localparam logic [1:0]  CLASS_BAD_LO = 2'd2;
	localparam logic [1:0]  CLASS_BAD_HI = 2'd3;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	req_t               req_word  = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	rsp_t               rsp_word;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] cfg_data  = '0;

	two_class_weighted_queue_arbiter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// arbiter shadow state, indexed by class (normal, urgent)
	logic [IN_ID_W-1:0] id_store [2][QUEUE_DEPTH];
	int                 store_rd  [2] = '{0, 0};
	int                 store_cnt [2] = '{0, 0};
	int                 burst_run     = 0;
	logic [LIMIT_W-1:0] burst_limit   = LIMIT_RESET;

	rsp_t        expected_rsp [$];
	int unsigned cycle_count   = 0;
	int unsigned words_sent    = 0;
	int unsigned words_checked = 0;
	int unsigned mismatches    = 0;
	int unsigned limits_used   = 0;
	int unsigned served_total  = 0;
	int unsigned full_total    = 0;
	int unsigned empty_total   = 0;
	int unsigned bad_total     = 0;
	int          tx_gap_pct    = 0;
	int          stall_pct     = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles", cycle_count);
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stall_gen
		int burst_len;
		forever begin
			@(posedge clk);
			if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				burst_len = $urandom_range(1, 18);
				rsp_stall <= 1'b1;
				for (int i = 0; i < burst_len && stall_pct > 0; i++)
					@(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	function automatic bit push_id(int q, logic [IN_ID_W-1:0] id);
		if (store_cnt[q] >= QUEUE_DEPTH)
			return 1'b0;
		id_store[q][(store_rd[q] + store_cnt[q]) % QUEUE_DEPTH] = id;
		store_cnt[q]++;
		return 1'b1;
	endfunction

	function automatic logic [IN_ID_W-1:0] pop_id(int q);
		logic [IN_ID_W-1:0] id;
		id = id_store[q][store_rd[q]];
		store_rd[q] = (store_rd[q] + 1) % QUEUE_DEPTH;
		store_cnt[q]--;
		return id;
	endfunction

	function automatic rsp_t arbitrate(req_t w);
		rsp_t r;
		bit   reached;
		r = '0;
		if (w.req_type == REQ_ENQUEUE) begin
			if (w.item_class == CLASS_URGENT) begin
				r.status = push_id(CLASS_URGENT, w.item_id) ? ST_ADD_URGENT : ST_FULL;
			end else if (w.item_class == CLASS_NORMAL) begin
				r.status = push_id(CLASS_NORMAL, w.item_id) ? ST_ADD_NORMAL : ST_FULL;
			end else begin
				r.status = ST_BAD_CLASS;
			end
		end else begin
			reached = burst_run >= int'(burst_limit);
			if (store_cnt[CLASS_NORMAL] != 0 && (reached || store_cnt[CLASS_URGENT] == 0)) begin
				r.served_id = pop_id(CLASS_NORMAL);
				burst_run = 0;
				r.status = ST_SERVED;
			end else if (store_cnt[CLASS_URGENT] != 0) begin
				r.served_id = pop_id(CLASS_URGENT);
				r.served_urgent = 1'b1;
				if (!reached)
					burst_run++;
				r.status = ST_SERVED;
			end else begin
				r.status = ST_EMPTY;
			end
		end
		r.urgent_waiting = WAIT_W'(store_cnt[CLASS_URGENT]);
		r.normal_waiting = WAIT_W'(store_cnt[CLASS_NORMAL]);
		r.total_waiting  = TOTAL_W'(store_cnt[CLASS_URGENT] + store_cnt[CLASS_NORMAL]);
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("%0t: response %0d %s mismatch: got %0h, want %0h",
				$time, words_checked, field, got, want);
		mismatches++;
	endtask

	task automatic check_word(rsp_t got);
		rsp_t want;
		if (expected_rsp.size() == 0) begin
			report_mismatch("unexpected word", 32'(got.status), '0);
			return;
		end
		want = expected_rsp.pop_front();
		if (got.status !== want.status)
			report_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.served_id !== want.served_id)
			report_mismatch("served_id", 32'(got.served_id), 32'(want.served_id));
		if (got.served_urgent !== want.served_urgent)
			report_mismatch("served_urgent", 32'(got.served_urgent),
				32'(want.served_urgent));
		if (got.urgent_waiting !== want.urgent_waiting)
			report_mismatch("urgent_waiting", 32'(got.urgent_waiting),
				32'(want.urgent_waiting));
		if (got.normal_waiting !== want.normal_waiting)
			report_mismatch("normal_waiting", 32'(got.normal_waiting),
				32'(want.normal_waiting));
		if (got.total_waiting !== want.total_waiting)
			report_mismatch("total_waiting", 32'(got.total_waiting),
				32'(want.total_waiting));
		case (want.status)
			ST_SERVED:    served_total++;
			ST_FULL:      full_total++;
			ST_EMPTY:     empty_total++;
			ST_BAD_CLASS: bad_total++;
			default: ;
		endcase
		words_checked++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				burst_limit = cfg_data;
			if (rsp_valid && !rsp_stall)
				check_word(rsp_word);
			if (req_valid && !req_stall)
				expected_rsp.push_back(arbitrate(req_word));
		end
	end

	function automatic req_t make_req(req_type_t kind, logic [IN_ID_W-1:0] id, logic [1:0] cls);
		req_t w;
		w.req_type   = kind;
		w.item_id    = id;
		w.item_class = cls;
		return w;
	endfunction

	function automatic req_t random_req(int enq_pct);
		req_t w;
		int   pick;
		pick = $urandom_range(0, 19);
		w.item_id = IN_ID_W'($urandom);
		if (pick < 9)
			w.item_class = CLASS_URGENT;
		else if (pick < 18)
			w.item_class = CLASS_NORMAL;
		else
			w.item_class = $urandom_range(0, 1) ? CLASS_BAD_HI : CLASS_BAD_LO;
		w.req_type = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQUEUE : REQ_DEQUEUE;
		return w;
	endfunction

	task automatic send_req(req_t w);
		int gap;
		req_word  <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		words_sent++;
		if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
			gap = $urandom_range(1, 18);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_responses();
		if (req_valid)
			req_valid <= 1'b0;
		while (words_checked < words_sent) @(posedge clk);
	endtask

	task automatic write_burst_limit(logic [LIMIT_W-1:0] value);
		drain_responses();
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limits_used++;
	endtask

	task automatic test_empty_and_bad_class();
		tx_gap_pct = 20;
		stall_pct  = 20;
		send_req(make_req(REQ_DEQUEUE, '0, CLASS_NORMAL));
		send_req(make_req(REQ_ENQUEUE, '1, CLASS_BAD_LO));
		send_req(make_req(REQ_ENQUEUE, '0, CLASS_BAD_HI));
		send_req(make_req(REQ_DEQUEUE, '1, CLASS_BAD_HI));
	endtask

	task automatic test_fifo_order();
		send_req(make_req(REQ_ENQUEUE, 16'hFFFF, CLASS_URGENT));
		send_req(make_req(REQ_ENQUEUE, 16'h0000, CLASS_URGENT));
		send_req(make_req(REQ_ENQUEUE, 16'hA5A5, CLASS_NORMAL));
		send_req(make_req(REQ_ENQUEUE, 16'h5A5A, CLASS_NORMAL));
		repeat (4) send_req(make_req(REQ_DEQUEUE, '0, CLASS_NORMAL));
	endtask

	task automatic test_burst_limit();
		write_burst_limit(LIMIT_W'(1));
		send_req(make_req(REQ_ENQUEUE, 16'h1111, CLASS_URGENT));
		send_req(make_req(REQ_ENQUEUE, 16'h2222, CLASS_URGENT));
		repeat (2) send_req(make_req(REQ_DEQUEUE, '0, CLASS_URGENT));
		send_req(make_req(REQ_ENQUEUE, 16'h3333, CLASS_NORMAL));
		send_req(make_req(REQ_ENQUEUE, 16'h4444, CLASS_URGENT));
		repeat (2) send_req(make_req(REQ_DEQUEUE, '0, CLASS_URGENT));
	endtask

	task automatic test_zero_limit();
		write_burst_limit('0);
		send_req(make_req(REQ_ENQUEUE, 16'h8001, CLASS_URGENT));
		send_req(make_req(REQ_ENQUEUE, 16'h7FFE, CLASS_NORMAL));
		repeat (2) send_req(make_req(REQ_DEQUEUE, '1, CLASS_NORMAL));
	endtask

	// swing the queues between full and empty in runs of enqueue, dequeue or even bias
	task automatic run_traffic(int items, bit idling);
		int sent;
		int run_len;
		int enq_pct;
		int mode;
		sent = 0;
		while (sent < items) begin
			run_len = $urandom_range(8, 40);
			mode    = $urandom_range(0, 2);
			enq_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
			if (idling) begin
				tx_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
				stall_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
			end else begin
				tx_gap_pct = 0;
				stall_pct  = 0;
			end
			for (int i = 0; i < run_len && sent < items; i++) begin
				send_req(random_req(enq_pct));
				sent++;
			end
		end
	endtask

	task automatic test_random_traffic();
		logic [LIMIT_W-1:0] fixed_limits [4];
		fixed_limits = '{'1, '0, LIMIT_W'(1), LIMIT_RESET};
		for (int phase = 0; phase < 7; phase++) begin
			if (phase < 4)
				write_burst_limit(fixed_limits[phase]);
			else
				write_burst_limit(LIMIT_W'($urandom_range(0, 15)));
			run_traffic(PHASE_ITEMS, 1'b1);
		end
	endtask

	task automatic test_back_to_back();
		write_burst_limit(LIMIT_W'($urandom_range(1, 14)));
		run_traffic(PHASE_ITEMS, 1'b0);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_bad_class();
		test_fifo_order();
		test_burst_limit();
		test_zero_limit();
		test_random_traffic();
		test_back_to_back();
		drain_responses();
		repeat (4) @(posedge clk);
		$display("Sent %0d requests under %0d burst limit settings, checked %0d responses",
			words_sent, limits_used, words_checked);
		$display("Served %0d, full %0d, both empty %0d, bad class %0d, mismatches %0d",
			served_total, full_total, empty_total, bad_total, mismatches);
		if (mismatches == 0 && expected_rsp.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
src/twqa_pkg.sv
src/twqa_ram.sv
src/two_class_weighted_queue_arbiter.sv
test/tb_two_class_weighted_queue_arbiter.sv
